@@ sv/civ_frame_receiver_unit_macros.svh @@
// ----------------------------------------------------------------------------
// CI-V frame receiver assertion macros
// Shared concurrent assertion forms for the frame receiver modules.
// ----------------------------------------------------------------------------
`ifndef CIV_FRAME_RECEIVER_UNIT_MACROS_SVH
`define CIV_FRAME_RECEIVER_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled while reset is asserted.
`define CIV_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CIV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define CIV_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define CIV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

@@ sv/civ_pkg.sv @@
// ----------------------------------------------------------------------------
// CI-V frame receiver package
// Types, codes and constants shared by the frame receiver modules.
// ----------------------------------------------------------------------------
package civ_pkg;

    typedef logic [7:0] t_byte;

    // Payload limit and derived counter widths.
    localparam int PAYLOAD_MAX = 16;
    localparam int CNT_W       = $clog2(PAYLOAD_MAX + 1);
    localparam int HEAD_DEPTH  = 6;
    localparam int HEAD_IDX_W  = $clog2(HEAD_DEPTH);
    localparam int BCD_BYTES   = HEAD_DEPTH - 1;
    localparam int LEN_W       = 5;
    localparam int HALF_W      = 15;
    localparam int FREQ_W      = 32;

    // Queue between parser and decoder.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration port.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_CTRL_ADDR  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_RADIO_ADDR = 1'b1;
    localparam t_byte CTRL_ADDR_RESET  = 8'hE0;
    localparam t_byte RADIO_ADDR_RESET = 8'h94;

    // Frame bytes and command codes.
    localparam t_byte PREAMBLE       = 8'hFE;
    localparam t_byte TERMINATOR     = 8'hFD;
    localparam t_byte BROADCAST_ADDR = 8'h00;
    localparam t_byte CMD_FREQ_XFER  = 8'h00;
    localparam t_byte CMD_MODE_XFER  = 8'h01;
    localparam t_byte CMD_FREQ_READ  = 8'h03;
    localparam t_byte CMD_MODE_READ  = 8'h04;
    localparam t_byte MODE_RESET     = 8'h01;
    localparam t_byte NIBBLE_MASK    = 8'h0F;

    // Decimal weights used by the frequency decoder.
    localparam logic [7:0]        W_DIGIT = 8'd10;
    localparam logic [HALF_W-1:0] W_PAIR  = 15'd100;
    localparam logic [FREQ_W-1:0] W_QUAD  = 32'd10000;
    localparam logic [FREQ_W-1:0] W_OCT   = 32'd100000000;

    typedef enum logic [2:0] {
        ST_HUNT0,
        ST_HUNT1,
        ST_DEST,
        ST_SRC,
        ST_PAYLOAD
    } t_parse_state;

    typedef enum logic [1:0] {
        KIND_OTHER,
        KIND_FREQ,
        KIND_MODE
    } t_frame_kind;

    // Frame summary common to every back-end stage.
    typedef struct packed {
        t_frame_kind          kind;
        logic [LEN_W-1:0]     frame_len;
        t_byte                cmd_byte;
        t_byte                first_data;
    } t_frame_info;

    // Complete frame handed from the parser to the decoder.
    typedef struct packed {
        t_frame_info                info;
        t_byte [BCD_BYTES-1:0]      bcd;
    } t_frame_desc;

    typedef struct packed {
        logic [LEN_W-1:0]  frame_len;
        t_byte             cmd_byte;
        t_byte             first_data;
        logic [FREQ_W-1:0] freq_hz;
        logic              freq_changed;
        t_byte             radio_mode_out;
        logic              mode_updated;
    } t_result;

    // Two BCD digits of one byte, taken as binary values (A..F included).
    function automatic logic [7:0] bcd_pair(input t_byte b);
        logic [7:0] lo;
        logic [7:0] hi;
        lo = b & NIBBLE_MASK;
        hi = (b >> 4) & NIBBLE_MASK;
        return lo + hi * W_DIGIT;
    endfunction

endpackage

@@ sv/civ_if.sv @@
// ----------------------------------------------------------------------------
// CI-V frame receiver channel interfaces
// Byte input, result output and configuration write channels.
// ----------------------------------------------------------------------------
interface civ_byte_if;
    import civ_pkg::*;
    logic  valid;
    logic  ready;
    t_byte rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface civ_result_if;
    import civ_pkg::*;
    logic              valid;
    logic              ready;
    logic [LEN_W-1:0]  frame_len;
    t_byte             cmd_byte;
    t_byte             first_data;
    logic [FREQ_W-1:0] freq_hz;
    logic              freq_changed;
    t_byte             radio_mode_out;
    logic              mode_updated;

    modport source (output valid, output frame_len, output cmd_byte, output first_data,
                    output freq_hz, output freq_changed, output radio_mode_out,
                    output mode_updated, input ready);
    modport sink   (input valid, input frame_len, input cmd_byte, input first_data,
                    input freq_hz, input freq_changed, input radio_mode_out,
                    input mode_updated, output ready);
endinterface

interface civ_cfg_if;
    import civ_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    t_byte                data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ sv/civ_frame_receiver_unit.sv @@
// ----------------------------------------------------------------------------
// CI-V frame receiver
// Finds radio control frames in a received byte stream and reports each
// frame with its length, command, data byte, frequency and mode.
// ----------------------------------------------------------------------------
//   Channel   Direction  Carries
//   i_rx      in         rx_byte, one received serial byte per transaction
//   i_cfg     in         index and data of a configuration register write
//   o_res     out        one result per terminated frame
//
// One byte is taken per cycle while the frame queue has room; once the queue
// is full every byte waits until the decoder takes a frame from it.
// After its terminator byte is taken, a frame passes through the queue, the
// three decoder stages and the output register before its result is valid.
// A stalled output holds the decoder pipeline; the four-entry queue absorbs
// the frames that end meanwhile before the byte input stalls.
// Reset is synchronous and active low; it restores both address registers,
// a frequency of zero and mode one.
module civ_frame_receiver_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    civ_byte_if.sink      i_rx,
    civ_cfg_if.sink       i_cfg,
    civ_result_if.source  o_res
);
    import civ_pkg::*;

    logic        push;
    logic        push_ready;
    t_frame_desc push_data;
    logic        pop;
    logic        pop_valid;
    t_frame_desc pop_data;

    // Parser and classifier.
    civ_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rx         (i_rx),
        .i_cfg        (i_cfg),
        .o_push       (push),
        .o_push_data  (push_data),
        .i_push_ready (push_ready)
    );

    // Frame queue between the two halves.
    civ_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_push_data  (push_data),
        .o_push_ready (push_ready),
        .o_pop_valid  (pop_valid),
        .o_pop_data   (pop_data),
        .i_pop        (pop)
    );

    // Frequency and mode decoder.
    civ_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (pop_valid),
        .i_pop_data  (pop_data),
        .o_pop       (pop),
        .o_res       (o_res)
    );

endmodule

@@ sv/civ_front.sv @@
// ----------------------------------------------------------------------------
// CI-V frame parser
// Hunts the preamble, checks addresses, collects the payload head and
// classifies each completed frame before handing it to the decoder queue.
// ----------------------------------------------------------------------------
module civ_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    civ_byte_if.sink             i_rx,
    civ_cfg_if.sink              i_cfg,
    output logic                 o_push,
    output civ_pkg::t_frame_desc o_push_data,
    input  logic                 i_push_ready
);
    import civ_pkg::*;

    t_parse_state   r_state;
    t_parse_state   n_state;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    t_byte          r_head [HEAD_DEPTH];
    t_byte          r_ctrl_addr;
    t_byte          r_radio_addr;
    logic           rx_fire;
    logic           head_wr;
    logic           is_fe;
    t_parse_state   miss_state;
    t_frame_desc    desc;

    assign rx_fire     = i_rx.valid && i_rx.ready;
    assign i_rx.ready  = i_push_ready;
    assign i_cfg.ready = 1'b1;
    assign is_fe       = (i_rx.rx_byte == PREAMBLE);
    assign miss_state  = is_fe ? ST_HUNT1 : ST_HUNT0;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl_addr  <= CTRL_ADDR_RESET;
            r_radio_addr <= RADIO_ADDR_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_CTRL_ADDR:  r_ctrl_addr  <= i_cfg.data;
                REG_RADIO_ADDR: r_radio_addr <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // Parser state and payload counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_HUNT0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    // Payload head store; entries at or above the count are read but hold stale bytes.
    always_ff @(posedge i_clk) begin
        if (head_wr) begin
            r_head[r_count[HEAD_IDX_W-1:0]] <= i_rx.rx_byte;
        end
    end

    // Next state, head writes and frame hand-off.
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        head_wr = 1'b0;
        o_push  = 1'b0;
        if (rx_fire) begin
            case (r_state)
                ST_HUNT0: begin
                    n_state = is_fe ? ST_HUNT1 : ST_HUNT0;
                end
                ST_HUNT1: begin
                    n_state = is_fe ? ST_DEST : ST_HUNT0;
                end
                ST_DEST: begin
                    if (i_rx.rx_byte == r_ctrl_addr || i_rx.rx_byte == BROADCAST_ADDR) begin
                        n_state = ST_SRC;
                    end else begin
                        n_state = miss_state;
                    end
                end
                ST_SRC: begin
                    n_state = (i_rx.rx_byte == r_radio_addr) ? ST_PAYLOAD : miss_state;
                    n_count = '0;
                end
                ST_PAYLOAD: begin
                    if (i_rx.rx_byte == TERMINATOR) begin
                        o_push  = 1'b1;
                        n_state = ST_HUNT0;
                    end else if (r_count < CNT_W'(PAYLOAD_MAX)) begin
                        head_wr = (r_count < CNT_W'(HEAD_DEPTH));
                        n_count = r_count + 1'b1;
                    end else begin
                        n_state = ST_HUNT0;
                    end
                end
                default: begin
                    n_state = ST_HUNT0;
                end
            endcase
        end
    end

    // Classification of the frame that ends with the current terminator.
    always_comb begin
        desc.info.frame_len  = LEN_W'(r_count);
        desc.info.cmd_byte   = (r_count != '0) ? r_head[0] : BROADCAST_ADDR;
        desc.info.first_data = (r_count > CNT_W'(1)) ? r_head[1] : BROADCAST_ADDR;
        desc.info.kind       = KIND_OTHER;
        if ((desc.info.cmd_byte == CMD_FREQ_XFER || desc.info.cmd_byte == CMD_FREQ_READ)
            && r_count >= CNT_W'(HEAD_DEPTH)) begin
            desc.info.kind = KIND_FREQ;
        end else if ((desc.info.cmd_byte == CMD_MODE_XFER
                      || desc.info.cmd_byte == CMD_MODE_READ)
                     && r_count > CNT_W'(1)) begin
            desc.info.kind = KIND_MODE;
        end
        for (int k = 0; k < BCD_BYTES; k++) begin
            desc.bcd[k] = r_head[k + 1];
        end
    end

    assign o_push_data = desc;

endmodule

@@ sv/civ_queue.sv @@
// ----------------------------------------------------------------------------
// CI-V frame queue
// Short first-in first-out buffer between the parser and the decoder.
// ----------------------------------------------------------------------------
module civ_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  civ_pkg::t_frame_desc i_push_data,
    output logic                 o_push_ready,
    output logic                 o_pop_valid,
    output civ_pkg::t_frame_desc o_pop_data,
    input  logic                 i_pop
);
    import civ_pkg::*;

    t_frame_desc       r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              push_fire;
    logic              pop_fire;

    assign o_push_ready = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_slot[r_rd_ptr];
    assign push_fire    = i_push && o_push_ready;
    assign pop_fire     = i_pop && o_pop_valid;

    // Slot storage.
    always_ff @(posedge i_clk) begin
        if (push_fire) begin
            r_slot[r_wr_ptr] <= i_push_data;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push_fire) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop_fire) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (push_fire && !pop_fire) begin
                r_count <= r_count + 1'b1;
            end else if (pop_fire && !push_fire) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

@@ sv/civ_back.sv @@
// ----------------------------------------------------------------------------
// CI-V frame decoder
// Decodes BCD frequency in three stages, updates the stored frequency and
// mode in order, and holds the result in the output register.
// ----------------------------------------------------------------------------
`include "civ_frame_receiver_unit_macros.svh"

module civ_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_pop_valid,
    input  civ_pkg::t_frame_desc i_pop_data,
    output logic                 o_pop,
    civ_result_if.source         o_res
);
    import civ_pkg::*;

    logic                        adv;

    // Stage 1: digit pairs.
    logic                        r_s1_valid;
    t_frame_info                 r_s1_info;
    logic [BCD_BYTES-1:0][7:0]   r_s1_pair;

    // Stage 2: four-digit halves and the top pair.
    logic                        r_s2_valid;
    t_frame_info                 r_s2_info;
    logic [HALF_W-1:0]           r_s2_lo;
    logic [HALF_W-1:0]           r_s2_mid;
    logic [7:0]                  r_s2_top;

    // Stage 3: full frequency word.
    logic                        r_s3_valid;
    t_frame_info                 r_s3_info;
    logic [FREQ_W-1:0]           r_s3_hz;

    // Stored radio state and output register.
    logic [FREQ_W-1:0]           r_tuned;
    t_byte                       r_mode;
    logic                        r_out_valid;
    t_result                     r_res;
    t_result                     n_res;
    logic [FREQ_W-1:0]           n_tuned;
    t_byte                       n_mode;

    // The whole pipeline moves whenever the output register can take a value.
    assign adv   = !r_out_valid || o_res.ready;
    assign o_pop = adv && i_pop_valid;

    // Valid bits of the pipeline.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_s1_valid  <= i_pop_valid;
            r_s2_valid  <= r_s1_valid;
            r_s3_valid  <= r_s2_valid;
            r_out_valid <= r_s3_valid;
        end
    end

    // Payload stages of the frequency decoder.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_info <= i_pop_data.info;
            for (int k = 0; k < BCD_BYTES; k++) begin
                r_s1_pair[k] <= bcd_pair(i_pop_data.bcd[k]);
            end
            r_s2_info <= r_s1_info;
            r_s2_lo   <= HALF_W'(r_s1_pair[0]) + HALF_W'(r_s1_pair[1]) * W_PAIR;
            r_s2_mid  <= HALF_W'(r_s1_pair[2]) + HALF_W'(r_s1_pair[3]) * W_PAIR;
            r_s2_top  <= r_s1_pair[4];
            r_s3_info <= r_s2_info;
            r_s3_hz   <= FREQ_W'(r_s2_lo) + FREQ_W'(r_s2_mid) * W_QUAD
                         + FREQ_W'(r_s2_top) * W_OCT;
        end
    end

    // Result of the frame leaving stage 3.
    always_comb begin
        n_tuned              = r_tuned;
        n_mode               = r_mode;
        n_res.frame_len      = r_s3_info.frame_len;
        n_res.cmd_byte       = r_s3_info.cmd_byte;
        n_res.first_data     = r_s3_info.first_data;
        n_res.freq_changed   = 1'b0;
        n_res.mode_updated   = 1'b0;
        case (r_s3_info.kind)
            KIND_FREQ: begin
                n_res.freq_changed = (r_s3_hz != r_tuned);
                n_tuned            = r_s3_hz;
            end
            KIND_MODE: begin
                n_res.mode_updated = 1'b1;
                n_mode             = r_s3_info.first_data;
            end
            default: ;
        endcase
        n_res.freq_hz        = n_tuned;
        n_res.radio_mode_out = n_mode;
    end

    // Stored frequency and mode.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tuned <= '0;
            r_mode  <= MODE_RESET;
        end else if (adv && r_s3_valid) begin
            r_tuned <= n_tuned;
            r_mode  <= n_mode;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_res <= n_res;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.frame_len      = r_res.frame_len;
    assign o_res.cmd_byte       = r_res.cmd_byte;
    assign o_res.first_data     = r_res.first_data;
    assign o_res.freq_hz        = r_res.freq_hz;
    assign o_res.freq_changed   = r_res.freq_changed;
    assign o_res.radio_mode_out = r_res.radio_mode_out;
    assign o_res.mode_updated   = r_res.mode_updated;

    // A frame is either a frequency report or a mode report, never both.
    `CIV_ASSERT_IMPL(a_one_kind, i_clk, i_rst_n, r_out_valid, !(r_res.freq_changed && r_res.mode_updated), "frequency and mode flags both set")
    // A frequency change needs a payload long enough for ten digits.
    `CIV_ASSERT_IMPL(a_freq_len, i_clk, i_rst_n, r_out_valid && r_res.freq_changed, r_res.frame_len >= LEN_W'(HEAD_DEPTH), "frequency change from a short frame")
    // A mode report shows its data byte as the stored mode.
    `CIV_ASSERT_IMPL(a_mode_out, i_clk, i_rst_n, r_out_valid && r_res.mode_updated, r_res.radio_mode_out == r_res.first_data, "mode report not reflected in stored mode")
    // A stalled result keeps the stored frequency unchanged.
    `CIV_ASSERT_NEXT(a_hold_freq, i_clk, i_rst_n, r_out_valid && !o_res.ready, r_tuned == $past(r_tuned), "stored frequency moved during a stall")

endmodule
